### rtl/bdlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

  // Widths of the count and configuration fields
  localparam int unsigned CountW = 6;
  localparam int unsigned LowW   = 4;
  localparam int unsigned HighW  = 6;
  localparam int unsigned TicksW = 12;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned IdxW   = 2;

  // Register reset values
  localparam logic [LowW-1:0]   LOW_LIMIT_RST  = 4'd2;
  localparam logic [HighW-1:0]  HIGH_LIMIT_RST = 6'd30;
  localparam logic [TicksW-1:0] LONG_TICKS_RST = 12'd2000;

  // Register indexes on the configuration port
  localparam logic [IdxW-1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [IdxW-1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [IdxW-1:0] REG_LONG_TICKS = 2'd2;

  typedef struct packed {
    logic [LowW-1:0]   low_limit;
    logic [HighW-1:0]  high_limit;
    logic [TicksW-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic raw_level;
    logic take_events;
  } sample_t;

  typedef struct packed {
    logic press_event;
    logic release_event;
    logic long_press_event;
    logic held;
  } result_t;

endpackage

`default_nettype wire

### rtl/bdlp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module bdlp_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [bdlp_pkg::IdxW-1:0]    cfg_index,
  input  wire logic [bdlp_pkg::CfgW-1:0]    cfg_data,
  output bdlp_pkg::cfg_t                    cfg
);

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit        <= bdlp_pkg::LOW_LIMIT_RST;
      cfg.high_limit       <= bdlp_pkg::HIGH_LIMIT_RST;
      cfg.long_press_ticks <= bdlp_pkg::LONG_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdlp_pkg::REG_LOW_LIMIT: begin
          cfg.low_limit <= cfg_data[bdlp_pkg::LowW-1:0];
        end
        bdlp_pkg::REG_HIGH_LIMIT: begin
          cfg.high_limit <= cfg_data[bdlp_pkg::HighW-1:0];
        end
        bdlp_pkg::REG_LONG_TICKS: begin
          cfg.long_press_ticks <= cfg_data[bdlp_pkg::TicksW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/bdlp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bdlp_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire bdlp_pkg::sample_t   sample_in,
  input  wire bdlp_pkg::cfg_t      cfg,
  output bdlp_pkg::result_t        result_next
);

  // Debounce state; the previous count always equals integ_count at tick start
  logic [bdlp_pkg::CountW-1:0] integ_count, integ_count_next;
  logic                        held_state, held_state_next;
  logic                        pending_press, pending_press_next;
  logic                        pending_release, pending_release_next;
  logic [bdlp_pkg::TicksW-1:0] hold_ticks, hold_ticks_next;
  logic                        long_fired, long_fired_next;

  logic signed [7:0]           step_sum;
  logic [bdlp_pkg::TicksW-1:0] lim;
  logic [bdlp_pkg::TicksW:0]   ticks_inc;
  logic                        press_set, release_set;
  logic                        long_hit;

  // Zero long-press setting acts as one
  assign lim = (cfg.long_press_ticks == '0) ? bdlp_pkg::TicksW'(1) : cfg.long_press_ticks;

  // Integrator step, clamp and flag update
  always_comb begin
    step_sum = $signed({2'b00, integ_count}) + (sample_in.raw_level ? 8'sd1 : -8'sd1);
    press_set        = 1'b0;
    release_set      = 1'b0;
    held_state_next  = held_state;
    if (step_sum < $signed({4'b0000, cfg.low_limit})) begin
      press_set        = (integ_count == {2'b00, cfg.low_limit});
      integ_count_next = (cfg.low_limit == '0) ? '0
                       : {2'b00, cfg.low_limit - bdlp_pkg::LowW'(1)};
      held_state_next  = 1'b1;
    end else if (step_sum > $signed({2'b00, cfg.high_limit})) begin
      release_set      = (integ_count == cfg.high_limit);
      integ_count_next = (cfg.high_limit == '1) ? '1
                       : cfg.high_limit + bdlp_pkg::HighW'(1);
      held_state_next  = 1'b0;
    end else begin
      integ_count_next = step_sum[bdlp_pkg::CountW-1:0];
    end
  end

  // Hold-tick counter, take handling and result
  always_comb begin
    ticks_inc = {1'b0, hold_ticks} + 13'd1;
    hold_ticks_next = hold_ticks;
    long_fired_next = long_fired;
    if (held_state_next) begin
      if (!long_fired) begin
        hold_ticks_next = (ticks_inc >= {1'b0, lim}) ? lim : ticks_inc[bdlp_pkg::TicksW-1:0];
      end
    end else begin
      hold_ticks_next = '0;
      long_fired_next = 1'b0;
    end

    long_hit = !long_fired_next && (hold_ticks_next >= lim);

    pending_press_next   = pending_press | press_set;
    pending_release_next = pending_release | release_set;

    result_next.press_event      = 1'b0;
    result_next.release_event    = 1'b0;
    result_next.long_press_event = 1'b0;
    result_next.held             = held_state_next;
    if (sample_in.take_events) begin
      result_next.press_event      = pending_press_next;
      result_next.release_event    = pending_release_next;
      result_next.long_press_event = long_hit;
      pending_press_next           = 1'b0;
      pending_release_next         = 1'b0;
      if (long_hit) begin
        long_fired_next = 1'b1;
      end
    end
  end

  // State commits only when the transaction moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_count     <= '0;
      held_state      <= 1'b0;
      pending_press   <= 1'b0;
      pending_release <= 1'b0;
      hold_ticks      <= '0;
      long_fired      <= 1'b0;
    end else if (advance) begin
      integ_count     <= integ_count_next;
      held_state      <= held_state_next;
      pending_press   <= pending_press_next;
      pending_release <= pending_release_next;
      hold_ticks      <= hold_ticks_next;
      long_fired      <= long_fired_next;
    end
  end

endmodule

`default_nettype wire

### rtl/button_debounce_long_press.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted sample passes the input register and then the output register before its result shows.
// Throughput: one sample per cycle while result_stall does not hold the output; the core's state update sets the pace.
// Reset (rst, synchronous): debounce state cleared, registers back to 2 / 30 / 2000,
// both pipeline registers emptied.
module button_debounce_long_press (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      sample_valid,
  output logic                           sample_stall,
  input  wire bdlp_pkg::sample_t         sample,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output bdlp_pkg::result_t              result,
  input  wire logic                      cfg_we,
  input  wire logic [bdlp_pkg::IdxW-1:0] cfg_index,
  input  wire logic [bdlp_pkg::CfgW-1:0] cfg_data
);

  bdlp_pkg::cfg_t    cfg;
  bdlp_pkg::sample_t in_reg;
  logic              in_reg_valid;
  bdlp_pkg::result_t result_next;
  logic              out_free;
  logic              advance;

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline flow control
  assign out_free     = !result_valid || !result_stall;
  assign advance      = in_reg_valid && out_free;
  assign sample_stall = in_reg_valid && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!sample_stall) begin
      in_reg_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      in_reg <= sample;
    end
  end

  bdlp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .sample_in   (in_reg),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  bdlp_pkg::sample_t             sample       = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  bdlp_pkg::result_t             result;
  logic                          cfg_we       = 1'b0;
  logic [bdlp_pkg::IdxW-1:0]     cfg_index    = bdlp_pkg::REG_LOW_LIMIT;
  logic [bdlp_pkg::CfgW-1:0]     cfg_data     = '0;

  // Predictor copy of the registers and debounce state
  logic [bdlp_pkg::LowW-1:0]     cfg_low;
  logic [bdlp_pkg::HighW-1:0]    cfg_high;
  logic [bdlp_pkg::TicksW-1:0]   cfg_ticks;
  logic [bdlp_pkg::CountW-1:0]   level_count;
  logic [bdlp_pkg::CountW-1:0]   last_count;
  logic                          is_held;
  logic                          press_flag;
  logic                          release_flag;
  logic [bdlp_pkg::TicksW-1:0]   held_ticks;
  logic                          long_done;

  bdlp_pkg::result_t             predicted_reports[$];
  int                            mismatch_count;

  // Idling controls for the sender gaps and the stall process
  bit                            send_gaps_on  = 1'b1;
  bit                            stall_gaps_on = 1'b1;
  int                            hold_off_left = 0;
  int                            stall_left    = 0;

  button_debounce_long_press i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("button_debounce_long_press regression: fail");
    $finish;
  end

  // Debounce predictor: one tick per accepted transaction
  function automatic bdlp_pkg::result_t debounce_tick(input bdlp_pkg::sample_t s);
    bdlp_pkg::result_t r;
    int      next_count;
    int      lim;
    int      t;
    r = '0;
    lim = (cfg_ticks == 0) ? 1 : int'(cfg_ticks);
    next_count = int'(level_count) + (s.raw_level ? 1 : -1);
    // low test wins when the limits overlap
    if (next_count < int'(cfg_low)) begin
      if (last_count == bdlp_pkg::CountW'(cfg_low)) press_flag = 1'b1;
      level_count = (cfg_low == 0) ? '0 : bdlp_pkg::CountW'(cfg_low - 1);
      is_held = 1'b1;
    end else if (next_count > int'(cfg_high)) begin
      if (last_count == cfg_high) release_flag = 1'b1;
      level_count = (cfg_high == 63) ? bdlp_pkg::CountW'(63)
                                     : bdlp_pkg::CountW'(cfg_high + 1);
      is_held = 1'b0;
    end else begin
      level_count = bdlp_pkg::CountW'(next_count);
    end
    // hold counter saturates, frozen once the long press fired
    if (is_held) begin
      if (!long_done) begin
        t = int'(held_ticks) + 1;
        if (t >= lim) t = lim;
        held_ticks = bdlp_pkg::TicksW'(t);
      end
    end else begin
      held_ticks = '0;
      long_done  = 1'b0;
    end
    last_count = level_count;
    if (s.take_events) begin
      r.press_event   = press_flag;
      r.release_event = release_flag;
      press_flag      = 1'b0;
      release_flag    = 1'b0;
      if (!long_done && int'(held_ticks) >= lim) begin
        r.long_press_event = 1'b1;
        long_done          = 1'b1;
      end
    end
    r.held = is_held;
    return r;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!send_gaps_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stalls, plus the long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        result_stall <= 1'b1;
        hold_off_left--;
      end else if (!stall_gaps_on) begin
        result_stall <= 1'b0;
      end else if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = stall_length() - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(input string what, input bdlp_pkg::result_t want,
                               input bdlp_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t: %s: expected press=%b release=%b long=%b held=%b, ",
                "got press=%b release=%b long=%b held=%b"},
               $time, what, want.press_event, want.release_event, want.long_press_event,
               want.held, got.press_event, got.release_event, got.long_press_event, got.held);
  endtask

  // Result checker
  always @(posedge clk) begin
    bdlp_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (predicted_reports.size() == 0) begin
        flag_mismatch("result with nothing expected", '0, result);
      end else begin
        want = predicted_reports.pop_front();
        if (result.press_event !== want.press_event) flag_mismatch("press_event", want, result);
        if (result.release_event !== want.release_event)
          flag_mismatch("release_event", want, result);
        if (result.long_press_event !== want.long_press_event)
          flag_mismatch("long_press_event", want, result);
        if (result.held !== want.held) flag_mismatch("held", want, result);
      end
    end
  end

  // One transaction on the sample channel; valid stays high for a back-to-back follower
  task automatic send_sample(input bdlp_pkg::sample_t s);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predicted_reports.push_back(debounce_tick(s));
  endtask

  task automatic send_pattern(input logic [31:0] levels, input logic [31:0] takes, input int n);
    bdlp_pkg::sample_t s;
    for (int i = 0; i < n; i++) begin
      s.raw_level   = levels[i];
      s.take_events = takes[i];
      send_sample(s);
    end
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdlp_pkg::IdxW-1:0] idx,
                           input logic [bdlp_pkg::CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      bdlp_pkg::REG_LOW_LIMIT:  cfg_low   = data[bdlp_pkg::LowW-1:0];
      bdlp_pkg::REG_HIGH_LIMIT: cfg_high  = data[bdlp_pkg::HighW-1:0];
      bdlp_pkg::REG_LONG_TICKS: cfg_ticks = data[bdlp_pkg::TicksW-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are written only with the block drained; unused upper data bits get junk
  task automatic configure(input int low, input int high, input int ticks);
    logic [bdlp_pkg::CfgW-1:0] data;
    drain();
    data = bdlp_pkg::CfgW'($urandom);
    data[bdlp_pkg::LowW-1:0] = bdlp_pkg::LowW'(low);
    write_reg(bdlp_pkg::REG_LOW_LIMIT, data);
    data = bdlp_pkg::CfgW'($urandom);
    data[bdlp_pkg::HighW-1:0] = bdlp_pkg::HighW'(high);
    write_reg(bdlp_pkg::REG_HIGH_LIMIT, data);
    write_reg(bdlp_pkg::REG_LONG_TICKS, bdlp_pkg::CfgW'(ticks));
  endtask

  // Mostly-steady run at one level with some contact bounce
  task automatic send_run(input logic lvl, input int len, input int bounce_pct);
    bdlp_pkg::sample_t s;
    for (int i = 0; i < len; i++) begin
      s.raw_level   = ($urandom_range(0, 99) < bounce_pct) ? ~lvl : lvl;
      s.take_events = ($urandom_range(0, 2) == 0);
      send_sample(s);
    end
  endtask

  // First ticks from reset: held without a press
  task automatic test_reset_start();
    send_pattern(32'b000, 32'b101, 3);
  endtask

  // Zero low limit and zero long press ticks, then a release; last take after untaken ticks
  task automatic test_zero_limits();
    configure(0, 3, 0);
    send_pattern(32'b1111100, 32'b1000011, 7);
  endtask

  // Low limit above the high limit
  task automatic test_overlap();
    configure(15, 5, 3);
    send_pattern(32'b110010, 32'b111111, 6);
  endtask

  // Long press fires once, hold counter frozen, release clears it
  task automatic test_long_press_once();
    configure(2, 6, 2);
    send_pattern(32'b111111_00000000, 32'b100000_10100000, 14);
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    bdlp_pkg::sample_t s;
    send_gaps_on  = 1'b0;
    hold_off_left = 80;
    for (int i = 0; i < 40; i++) begin
      s = bdlp_pkg::sample_t'(2'($urandom_range(0, 3)));
      send_sample(s);
    end
    while (hold_off_left > 0) @(posedge clk);
    send_gaps_on = 1'b1;
    drain();
  endtask

  // Press and release sequences with random bounce, some cut short, some pure noise
  task automatic test_random_setting(input int low, input int high, input int ticks,
                                     input int budget);
    int   sent;
    int   span;
    int   len;
    int   lim;
    logic lvl;
    configure(low, high, ticks);
    span = int'(cfg_high) - int'(cfg_low) + 2;
    if (span < 4) span = 4;
    lim  = (cfg_ticks == 0) ? 1 : int'(cfg_ticks);
    lvl  = 1'b0;
    sent = 0;
    while (sent < budget) begin
      send_gaps_on  = ($urandom_range(0, 6) != 0);
      stall_gaps_on = send_gaps_on;
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(3, 20);
        send_run(lvl, len, 50);
      end else begin
        len = span + span / 2 + $urandom_range(0, span);
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, span / 2 + 1);
        if (!lvl && lim <= 150 && $urandom_range(0, 1) == 1) len += lim;
        send_run(lvl, len, $urandom_range(0, 15));
        lvl = ~lvl;
      end
      sent += len;
    end
    send_gaps_on  = 1'b1;
    stall_gaps_on = 1'b1;
    drain();
  endtask

  initial begin
    cfg_low        = bdlp_pkg::LOW_LIMIT_RST;
    cfg_high       = bdlp_pkg::HIGH_LIMIT_RST;
    cfg_ticks      = bdlp_pkg::LONG_TICKS_RST;
    level_count    = '0;
    last_count     = '0;
    is_held        = 1'b0;
    press_flag     = 1'b0;
    release_flag   = 1'b0;
    held_ticks     = '0;
    long_done      = 1'b0;
    mismatch_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_start();
    test_zero_limits();
    test_overlap();
    test_long_press_once();
    test_backpressure();
    test_random_setting(1, 16, 1, 140);
    test_random_setting(15, 62, 4095, 150);
    test_random_setting(0, 63, 0, 180);
    test_random_setting(15, 5, 3, 100);
    test_random_setting(4, 20, 40, 140);
    test_random_setting(7, 40, 120, 150);
    test_random_setting($urandom_range(0, 15), $urandom_range(0, 63),
                        $urandom_range(0, 150), 120);
    test_random_setting($urandom_range(0, 15), $urandom_range(0, 63),
                        $urandom_range(0, 150), 120);

    drain();
    if (mismatch_count == 0) begin
      $display("button_debounce_long_press regression: pass");
    end else begin
      $display("button_debounce_long_press regression: fail");
    end
    $finish;
  end

endmodule
